[hdl/gray_crop_nearest_downsampler_unit_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the grey crop / downsample block
// Each macro expands to one labeled concurrent assertion on clk / rst_n.
// ----------------------------------------------------------------------------
`ifndef GRAY_CROP_NEAREST_DOWNSAMPLER_UNIT_DEFINES_SVH
`define GRAY_CROP_NEAREST_DOWNSAMPLER_UNIT_DEFINES_SVH

// Same-cycle implication
`define GCND_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define GCND_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/gcnd_pkg.sv]
// ----------------------------------------------------------------------------
// gcnd_pkg
// Shared types and constants of the grey crop / nearest downsampler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gcnd_pkg;

  localparam int SRC_W      = 10;  // source coordinate / size width
  localparam int OFFSET_W   = 7;   // crop offset width (max 125)
  localparam int WEIGHT_W   = 16;  // Q0.16 weight
  localparam int CHAN_W     = 8;   // one color channel
  localparam int GRAY_W     = 16;  // Q8.8 grey level
  localparam int COORD_W    = 7;   // output coordinate field
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_RED    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_GREEN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_BLUE   = 3'd4;

  // Reset values (height 210 gives usable height 180, crop offset 25)
  localparam logic [SRC_W-1:0]    RST_SOURCE_WIDTH  = 10'd160;
  localparam logic [SRC_W-1:0]    RST_USABLE_HEIGHT = 10'd180;
  localparam logic [OFFSET_W-1:0] RST_CROP_OFFSET   = 7'd25;
  localparam logic [WEIGHT_W-1:0] RST_WEIGHT_RED    = 16'd19589;
  localparam logic [WEIGHT_W-1:0] RST_WEIGHT_GREEN  = 16'd38529;
  localparam logic [WEIGHT_W-1:0] RST_WEIGHT_BLUE   = 16'd7471;

  // Source row counter saturates here
  localparam logic [SRC_W-1:0] SRC_ROW_MAX = 10'd1023;

  // floor(6*H/7) = (H * 6 * 9363) >> 16 and floor(6*H/49) = (H * 6 * 21400) >> 20,
  // exact for every 10-bit H
  localparam logic [15:0] HC_RECIP     = 16'd56178;
  localparam logic [16:0] OFFSET_RECIP = 17'd128400;

  typedef struct packed {
    logic [SRC_W-1:0]    source_width;
    logic [SRC_W-1:0]    usable_height;
    logic [OFFSET_W-1:0] crop_offset;
    logic [WEIGHT_W-1:0] weight_red;
    logic [WEIGHT_W-1:0] weight_green;
    logic [WEIGHT_W-1:0] weight_blue;
  } cfg_t;

  typedef struct packed {
    logic               emit;
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;
    logic               frame_done;
  } sel_t;

endpackage

[hdl/gcnd_cfg.sv]
// ----------------------------------------------------------------------------
// gcnd_cfg
// Configuration registers; derives usable height and crop offset on write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gcnd_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [gcnd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gcnd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output gcnd_pkg::cfg_t                     cfg
);
  import gcnd_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic [SRC_W-1:0] height;
  logic [25:0]      hc_prod;
  logic [26:0]      off_prod;

  // Constant multiplies replace the divisions by 7 and 49
  assign height   = cfg_wdata[SRC_W-1:0];
  assign hc_prod  = 26'(height) * 26'(HC_RECIP);
  assign off_prod = 27'(height) * 27'(OFFSET_RECIP);

  // Write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_SOURCE_WIDTH:  cfg_nxt.source_width = cfg_wdata[SRC_W-1:0];
        REG_SOURCE_HEIGHT: begin
          cfg_nxt.usable_height = hc_prod[25:16];
          cfg_nxt.crop_offset   = off_prod[26:20];
        end
        REG_WEIGHT_RED:    cfg_nxt.weight_red   = cfg_wdata;
        REG_WEIGHT_GREEN:  cfg_nxt.weight_green = cfg_wdata;
        REG_WEIGHT_BLUE:   cfg_nxt.weight_blue  = cfg_wdata;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.source_width  <= RST_SOURCE_WIDTH;
      cfg_r.usable_height <= RST_USABLE_HEIGHT;
      cfg_r.crop_offset   <= RST_CROP_OFFSET;
      cfg_r.weight_red    <= RST_WEIGHT_RED;
      cfg_r.weight_green  <= RST_WEIGHT_GREEN;
      cfg_r.weight_blue   <= RST_WEIGHT_BLUE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[hdl/gcnd_sel.sv]
// ----------------------------------------------------------------------------
// gcnd_sel
// Raster counters and nearest-neighbor pixel selection with crop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gcnd_sel #(
  parameter int OUT_WIDTH  = 84,
  parameter int OUT_HEIGHT = 84
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,         // a pixel word is accepted
  input  logic           frame_start,
  input  gcnd_pkg::cfg_t cfg,
  output gcnd_pkg::sel_t sel
);
  import gcnd_pkg::*;

  // Column k is chosen when (src_col+1)*OUT_WIDTH > k-th accumulated width,
  // i.e. src_col >= floor(acc/OUT_WIDTH); rows work the same way.
  localparam int OCW = $clog2(OUT_WIDTH + 1);
  localparam int ORW = $clog2(OUT_HEIGHT + 1);
  localparam int CMW = $clog2(OUT_WIDTH) + 11;
  localparam int RMW = $clog2(OUT_HEIGHT) + 11;

  localparam logic [CMW-1:0] COL_STEP    = CMW'(OUT_WIDTH);
  localparam logic [RMW-1:0] ROW_STEP    = RMW'(OUT_HEIGHT);
  localparam logic [RMW-1:0] ROW_ACC_RST = RMW'(int'(RST_CROP_OFFSET) * OUT_HEIGHT);
  localparam logic [OCW-1:0] OUT_COLS    = OCW'(OUT_WIDTH);
  localparam logic [ORW-1:0] OUT_ROWS    = ORW'(OUT_HEIGHT);
  localparam logic [OCW-1:0] LAST_COL    = OCW'(OUT_WIDTH - 1);
  localparam logic [ORW-1:0] LAST_ROW    = ORW'(OUT_HEIGHT - 1);

  logic [SRC_W-1:0] src_col_r, src_col_nxt, src_col_e;
  logic [SRC_W-1:0] src_row_r, src_row_nxt, src_row_e;
  logic [CMW-1:0]   col_mul_r, col_mul_nxt, col_mul_e;
  logic [CMW-1:0]   col_acc_r, col_acc_nxt, col_acc_e;
  logic [OCW-1:0]   out_col_r, out_col_nxt, out_col_e;
  logic [RMW-1:0]   row_mul_r, row_mul_nxt, row_mul_e;
  logic [RMW-1:0]   row_acc_r, row_acc_nxt, row_acc_e;
  logic [ORW-1:0]   out_row_r, out_row_nxt, out_row_e;
  logic             row_active, emit, row_end;

  // State as seen by this pixel; a frame start clears it first
  always_comb begin
    src_col_e = frame_start ? '0       : src_col_r;
    col_mul_e = frame_start ? COL_STEP : col_mul_r;
    col_acc_e = frame_start ? '0       : col_acc_r;
    out_col_e = frame_start ? '0       : out_col_r;
    src_row_e = frame_start ? '0       : src_row_r;
    row_mul_e = frame_start ? ROW_STEP : row_mul_r;
    row_acc_e = frame_start ? RMW'(cfg.crop_offset) * ROW_STEP : row_acc_r;
    out_row_e = frame_start ? '0       : out_row_r;
  end

  assign row_active = (out_row_e < OUT_ROWS) && (row_mul_e > row_acc_e);
  assign emit       = row_active && (out_col_e < OUT_COLS) && (col_mul_e > col_acc_e);
  assign row_end    = ({1'b0, src_col_e} + 11'd1) >= {1'b0, cfg.source_width};

  // Counter advance
  always_comb begin
    src_col_nxt = src_col_e + 10'd1;
    col_mul_nxt = col_mul_e + COL_STEP;
    col_acc_nxt = col_acc_e;
    out_col_nxt = out_col_e;
    src_row_nxt = src_row_e;
    row_mul_nxt = row_mul_e;
    row_acc_nxt = row_acc_e;
    out_row_nxt = out_row_e;
    if (emit) begin
      col_acc_nxt = col_acc_e + CMW'(cfg.source_width);
      out_col_nxt = out_col_e + OCW'(1);
    end
    if (row_end) begin
      src_col_nxt = '0;
      col_mul_nxt = COL_STEP;
      col_acc_nxt = '0;
      out_col_nxt = '0;
      if (row_active) begin
        row_acc_nxt = row_acc_e + RMW'(cfg.usable_height);
        out_row_nxt = out_row_e + ORW'(1);
      end
      if (src_row_e != SRC_ROW_MAX) begin
        src_row_nxt = src_row_e + 10'd1;
        row_mul_nxt = row_mul_e + ROW_STEP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_col_r <= '0;
      col_mul_r <= COL_STEP;
      col_acc_r <= '0;
      out_col_r <= '0;
      src_row_r <= '0;
      row_mul_r <= ROW_STEP;
      row_acc_r <= ROW_ACC_RST;
      out_row_r <= '0;
    end else if (step) begin
      src_col_r <= src_col_nxt;
      col_mul_r <= col_mul_nxt;
      col_acc_r <= col_acc_nxt;
      out_col_r <= out_col_nxt;
      src_row_r <= src_row_nxt;
      row_mul_r <= row_mul_nxt;
      row_acc_r <= row_acc_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  assign sel.emit       = emit;
  assign sel.out_x      = COORD_W'(out_col_e);
  assign sel.out_y      = COORD_W'(out_row_e);
  assign sel.frame_done = (out_col_e == LAST_COL) && (out_row_e == LAST_ROW);

endmodule

[hdl/gcnd_luma.sv]
// ----------------------------------------------------------------------------
// gcnd_luma
// Weighted RGB to Q8.8 grey with saturation, registered result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gcnd_luma (
  input  logic                            clk,
  input  logic                            load,
  input  logic [gcnd_pkg::CHAN_W-1:0]     red,
  input  logic [gcnd_pkg::CHAN_W-1:0]     green,
  input  logic [gcnd_pkg::CHAN_W-1:0]     blue,
  input  gcnd_pkg::cfg_t                  cfg,
  output logic [gcnd_pkg::GRAY_W-1:0]     gray
);
  import gcnd_pkg::*;

  logic [23:0]       prod_r_c, prod_g_c, prod_b_c;
  logic [25:0]       acc;
  logic [GRAY_W-1:0] gray_r, gray_nxt;

  // Three parallel 8x16 products and their sum
  assign prod_r_c = 24'(red)   * 24'(cfg.weight_red);
  assign prod_g_c = 24'(green) * 24'(cfg.weight_green);
  assign prod_b_c = 24'(blue)  * 24'(cfg.weight_blue);
  assign acc      = 26'(prod_r_c) + 26'(prod_g_c) + 26'(prod_b_c);

  // Drop 8 fraction bits, clamp at full scale
  assign gray_nxt = (|acc[25:24]) ? '1 : acc[23:8];

  always_ff @(posedge clk) begin
    if (load) begin
      gray_r <= gray_nxt;
    end
  end

  assign gray = gray_r;

endmodule

[hdl/gray_crop_nearest_downsampler_unit.sv]
// ----------------------------------------------------------------------------
// gray_crop_nearest_downsampler_unit
// RGB to grey conversion with vertical crop and nearest-neighbor downscale.
// ----------------------------------------------------------------------------
// Input channel (in_*): one RGB source pixel per word in raster order;
// in_tuser marks the first pixel of a frame and restarts all counters.
// Output channel (out_*): one grey sample per selected pixel with its output
// column and row; out_tlast marks the last sample of the output frame.
// Configuration (cfg_*): width, height and the three weights, written one
// per cycle while no pixel is in flight; a height write takes effect at
// the next frame start for the crop offset, at once for the row step.
// Throughput: one pixel per clock unless a stalled receiver drops in_tready.
// Counters and the select decision act in the accept cycle; the stage register
// holds the pixel and the multiply-add fills the output register from it.
// Pixels that are not selected leave no word and never stall the input.
// A stalled receiver holds the output word; one more selected pixel waits
// in the stage register, after which in_tready drops until out_tready.
// Reset (synchronous): counters cleared, crop offset for a height of 210,
// registers at their defaults, both channels empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gray_crop_nearest_downsampler_unit_defines.svh"

module gray_crop_nearest_downsampler_unit #(
  parameter int OUT_WIDTH  = 84,
  parameter int OUT_HEIGHT = 84
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input pixel stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [23:0]                       in_tdata,   // red, green, blue
  input  logic                              in_tuser,   // frame_start
  // output sample stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [31:0]                       out_tdata,  // gray_sample, out_x, out_y, pad
  output logic                              out_tlast,  // frame_done
  // configuration
  input  logic                              cfg_we,
  input  logic [gcnd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gcnd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import gcnd_pkg::*;

  cfg_t cfg;
  sel_t sel;

  logic in_acc, advance;
  logic s1_valid_r, s1_valid_nxt;
  logic [CHAN_W-1:0]  s1_red_r, s1_green_r, s1_blue_r;
  sel_t               s1_sel_r;
  logic               out_valid_r, out_valid_nxt;
  logic [COORD_W-1:0] out_x_r, out_y_r;
  logic               out_last_r;
  logic [GRAY_W-1:0]  gray;

  gcnd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  gcnd_sel #(
    .OUT_WIDTH  (OUT_WIDTH),
    .OUT_HEIGHT (OUT_HEIGHT)
  ) u_sel (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (in_acc),
    .frame_start (in_tuser),
    .cfg         (cfg),
    .sel         (sel)
  );

  // Handshake: output register drains, stage register refills
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign in_acc    = in_tvalid && in_tready;

  assign s1_valid_nxt  = in_tready ? (in_acc && sel.emit) : s1_valid_r;
  assign out_valid_nxt = advance ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Stage register: pixel and its output position
  always_ff @(posedge clk) begin
    if (in_tready) begin
      s1_red_r   <= in_tdata[7:0];
      s1_green_r <= in_tdata[15:8];
      s1_blue_r  <= in_tdata[23:16];
      s1_sel_r   <= sel;
    end
  end

  gcnd_luma u_luma (
    .clk   (clk),
    .load  (advance),
    .red   (s1_red_r),
    .green (s1_green_r),
    .blue  (s1_blue_r),
    .cfg   (cfg),
    .gray  (gray)
  );

  // Output register: coordinates and end-of-frame mark
  always_ff @(posedge clk) begin
    if (advance) begin
      out_x_r    <= s1_sel_r.out_x;
      out_y_r    <= s1_sel_r.out_y;
      out_last_r <= s1_sel_r.frame_done;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_y_r, out_x_r, gray};
  assign out_tlast  = out_last_r;

  // Checks
  `GCND_ASSERT_NOW(a_stall_only_when_full, !in_tready, s1_valid_r && out_valid_r && !out_tready, "input stalled while a stage is free")
  `GCND_ASSERT_NEXT(a_emit_captured, in_acc && sel.emit, s1_valid_r, "selected pixel not captured")
  `GCND_ASSERT_NEXT(a_stage_drains, s1_valid_r && !out_valid_r, out_valid_r, "stage word did not reach empty output")

endmodule
